FILE: rtl/dpba_pkg.sv
// Shared types, constants and helper functions of the display plane bitmap allocator.
`default_nettype none

package dpba_pkg;

  // Plane count limit and map geometry
  localparam int unsigned MAX_PLANES = 32;
  localparam int unsigned MAP_W      = 32;
  localparam int unsigned NTYPES     = 3;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned IDX_W      = 5;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_PRIMARY_COUNT = 2'd0;
  localparam logic [1:0] REG_SPRITE_COUNT  = 2'd1;
  localparam logic [1:0] REG_OVERLAY_COUNT = 2'd2;

  // Plane type codes
  localparam logic [1:0] PT_PRIMARY = 2'd0;
  localparam logic [1:0] PT_SPRITE  = 2'd1;
  localparam logic [1:0] PT_OVERLAY = 2'd2;
  localparam logic [1:0] PT_INVALID = 2'd3;

  // Operation codes
  typedef enum logic [2:0] {
    FN_GET   = 3'd0,
    FN_PUT   = 3'd1,
    FN_RECL  = 3'd2,
    FN_FLUSH = 3'd3,
    FN_INIT  = 3'd4,
    FN_QUERY = 3'd5
  } func_t;

  // One request word
  typedef struct packed {
    logic [2:0]       func;
    logic [1:0]       plane_type;
    logic [IDX_W-1:0] plane_index;
  } op_t;

  // One result word; ok lands in the lowest bit when packed
  typedef struct packed {
    logic [MAP_W-1:0] overlay_disabled_mask;
    logic [MAP_W-1:0] primary_disabled_mask;
    logic [MAP_W-1:0] sprite_disabled_mask;
    logic             index_available;
    logic             has_reclaimed;
    logic             any_free;
    logic [CNT_W-1:0] free_count;
    logic [IDX_W-1:0] granted_index;
    logic             ok;
  } res_t;

  // Plane counts, indexed by plane type
  typedef logic [NTYPES-1:0][CNT_W-1:0] counts_t;

  typedef logic [NTYPES-1:0][MAP_W-1:0] maps_t;

  // Mask of the low count bits, count saturated to MAX_PLANES
  function automatic logic [MAP_W-1:0] low_mask(input logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] sat;
    logic [MAP_W-1:0] m;
    sat = (32'(count) > MAX_PLANES) ? CNT_W'(MAX_PLANES) : count;
    if (32'(sat) >= MAP_W) begin
      m = '1;
    end else begin
      m = (MAP_W'(1) << sat) - MAP_W'(1);
    end
    return m;
  endfunction

  // Index of the lowest set bit (0 when none is set)
  function automatic logic [IDX_W-1:0] lowest_index(input logic [MAP_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  // Population count of a map
  function automatic logic [CNT_W-1:0] pop_count(input logic [MAP_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAP_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/display_plane_bitmap_allocator_core.sv
// Top level of the display plane bitmap allocator: stream ports, staging and result registers.
// One request word is accepted per cycle while the result stream keeps up; it is staged in the
// input register, and its result word is loaded into the result register once the result slot
// is free or being emptied. A result word that waits for out_tready holds the staged request
// and so stalls the request stream. Throughput is one word per cycle under the same condition,
// set by the read-modify-write of the free and reclaimed bitmaps, where the priority encoder
// and population count sit. Plane counts are written over the APB-style port (primary at 0x0,
// sprite at 0x4, overlay at 0x8); they are to be written only while the block is idle, which
// the block itself does not enforce. An init request loads the free maps from them.
`default_nettype none

module display_plane_bitmap_allocator_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Request stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [4:0] plane_index, [7:5] zero
  input  wire logic [4:0]   in_tuser,   // [2:0] func, [4:3] plane_type
  // Result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // [0] ok, [5:1] granted_index, [11:6] free_count,
                                        // [12] any_free, [13] has_reclaimed,
                                        // [14] index_available, [46:15] sprite_disabled_mask,
                                        // [78:47] primary_disabled_mask,
                                        // [110:79] overlay_disabled_mask, [111] zero
  // Configuration port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import dpba_pkg::*;

  logic    in_valid_r;
  op_t     op_r;
  logic    out_valid_r;
  res_t    res_r;
  res_t    res;
  counts_t counts;
  logic    advance;

  // Work moves forward when a request is staged and the result slot is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  dpba_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .counts      (counts)
  );

  dpba_alloc u_alloc (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .op     (op_r),
    .counts (counts),
    .res    (res)
  );

  // Input staging register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r.func        <= in_tuser[2:0];
      op_r.plane_type  <= in_tuser[4:3];
      op_r.plane_index <= in_tdata[IDX_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

`default_nettype wire

FILE: rtl/dpba_cfg_regs.sv
// APB-style register file holding the three plane counts.
`default_nettype none

module dpba_cfg_regs (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [3:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready,
  output dpba_pkg::counts_t          counts
);
  import dpba_pkg::*;

  counts_t    counts_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign counts     = counts_r;

  // Register writes; addresses beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PRIMARY_COUNT: counts_r[0] <= cfg_pwdata[CNT_W-1:0];
        REG_SPRITE_COUNT:  counts_r[1] <= cfg_pwdata[CNT_W-1:0];
        REG_OVERLAY_COUNT: counts_r[2] <= cfg_pwdata[CNT_W-1:0];
        default:           ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_PRIMARY_COUNT: cfg_prdata = 32'(counts_r[0]);
      REG_SPRITE_COUNT:  cfg_prdata = 32'(counts_r[1]);
      REG_OVERLAY_COUNT: cfg_prdata = 32'(counts_r[2]);
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/dpba_alloc.sv
// Free and reclaimed bitmaps with the combinational operation logic.
`default_nettype none

module dpba_alloc (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire dpba_pkg::op_t     op,
  input  wire dpba_pkg::counts_t counts,
  output dpba_pkg::res_t         res
);
  import dpba_pkg::*;

  maps_t free_r,  free_nxt;
  maps_t recl_r,  recl_nxt;
  logic  init_r,  init_nxt;

  logic             type_ok;
  logic [1:0]       t;
  logic [MAP_W-1:0] avail;
  logic [MAP_W-1:0] idx_bit;
  logic [NTYPES-1:0][MAP_W-1:0] fmask;

  assign type_ok = (op.plane_type != PT_INVALID);
  assign t       = type_ok ? op.plane_type : PT_PRIMARY;
  assign avail   = free_r[t] | recl_r[t];
  assign idx_bit = MAP_W'(1) << op.plane_index;

  // Operation decode and map update
  always_comb begin
    free_nxt = free_r;
    recl_nxt = recl_r;
    init_nxt = init_r;
    res      = '0;
    fmask    = '0;
    case (func_t'(op.func))
      FN_GET: begin
        if (init_r && type_ok) begin
          if (t == PT_PRIMARY) begin
            if (32'(op.plane_index) < MAX_PLANES) begin
              if (recl_r[0][op.plane_index]) begin
                recl_nxt[0]       = recl_r[0] & ~idx_bit;
                res.ok            = 1'b1;
                res.granted_index = op.plane_index;
              end else if (free_r[0][op.plane_index]) begin
                free_nxt[0]       = free_r[0] & ~idx_bit;
                res.ok            = 1'b1;
                res.granted_index = op.plane_index;
              end
            end
          end else if (recl_r[t] != '0) begin
            res.ok            = 1'b1;
            res.granted_index = lowest_index(recl_r[t]);
            recl_nxt[t]       = recl_r[t] & (recl_r[t] - MAP_W'(1));
          end else if (free_r[t] != '0) begin
            res.ok            = 1'b1;
            res.granted_index = lowest_index(free_r[t]);
            free_nxt[t]       = free_r[t] & (free_r[t] - MAP_W'(1));
          end
        end
      end
      FN_PUT: begin
        if ((op.plane_type == PT_SPRITE || op.plane_type == PT_OVERLAY) &&
            !free_r[t][op.plane_index]) begin
          free_nxt[t] = free_r[t] | idx_bit;
          res.ok      = 1'b1;
        end
      end
      FN_RECL: begin
        if (init_r && type_ok && !recl_r[t][op.plane_index]) begin
          recl_nxt[t] = recl_r[t] | idx_bit;
          res.ok      = 1'b1;
        end
      end
      FN_FLUSH: begin
        if (init_r) begin
          for (int i = 0; i < NTYPES; i++) begin
            if (counts[i] != '0 && recl_r[i] != '0) begin
              fmask[i]    = recl_r[i] & low_mask(counts[i]);
              free_nxt[i] = free_r[i] | recl_r[i];
              recl_nxt[i] = '0;
            end
          end
          res.ok                    = 1'b1;
          res.primary_disabled_mask = fmask[0];
          res.sprite_disabled_mask  = fmask[1];
          res.overlay_disabled_mask = fmask[2];
        end
      end
      FN_INIT: begin
        for (int i = 0; i < NTYPES; i++) begin
          free_nxt[i] = low_mask(counts[i]);
          recl_nxt[i] = '0;
        end
        init_nxt = 1'b1;
        res.ok   = 1'b1;
      end
      FN_QUERY: begin
        if (init_r && type_ok) begin
          res.ok              = 1'b1;
          res.free_count      = pop_count(avail);
          res.any_free        = (avail != '0);
          res.has_reclaimed   = (recl_r[t] != '0);
          res.index_available = avail[op.plane_index];
        end
      end
      default: ;
    endcase
  end

  // Map state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
      recl_r <= '0;
      init_r <= 1'b0;
    end else if (step) begin
      free_r <= free_nxt;
      recl_r <= recl_nxt;
      init_r <= init_nxt;
    end
  end

  // Before init only put and init may succeed
  a_uninit_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !init_r && op.func != FN_PUT && op.func != FN_INIT) |-> !res.ok)
    else $error("operation succeeded before init");

  // A granted plane was free or reclaimed when it was handed out
  a_grant_avail: assert property (@(posedge clk) disable iff (!rst_n)
    (step && op.func == FN_GET && res.ok) |-> avail[res.granted_index])
    else $error("granted plane was not available");

  // Init leaves the block initialized with empty reclaimed maps
  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && op.func == FN_INIT) |=> (init_r && recl_r == '0))
    else $error("init did not clear reclaimed maps");

  // Flush only reports planes that were reclaimed
  a_flush_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (step && op.func == FN_FLUSH) |->
      ((res.primary_disabled_mask & ~recl_r[0]) == '0 &&
       (res.sprite_disabled_mask  & ~recl_r[1]) == '0 &&
       (res.overlay_disabled_mask & ~recl_r[2]) == '0))
    else $error("flush reported a plane that was not reclaimed");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the display plane bitmap allocator core.
`timescale 1ns / 1ps

module testbench;
  import dpba_pkg::*;

  // Unused operation codes; the block must reject them
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 10;
  localparam int WORDS_PER_PH = 200;
  localparam int OPENING_ROWS = 27;

  // One row of the opening sequence; grant/ok are typed in only where known is set
  typedef struct packed {
    logic [2:0] fn;
    logic [1:0] pt;
    logic [4:0] ix;
    logic       known;
    logic       ok;
    logic [4:0] grant;
  } op_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;     // [4:0] plane_index, [7:5] zero
  logic [4:0]   in_tuser = '0;     // [2:0] func, [4:3] plane_type
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;         // res_t in [110:0], ok lowest
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Allocator state as the block should hold it
  logic [31:0] free_map [3];
  logic [31:0] recl_map [3];
  logic [5:0]  plane_cnt [3];
  logic        alloc_ready = 1'b0;

  res_t pending_results [$];
  int   mismatches = 0;
  int   cycles = 0;
  logic quiet = 1'b0;              // no idling on either side while set

  op_row_t opening [0:OPENING_ROWS-1] = '{
    // before init; counts are primary 2, sprite 63 (saturates), overlay 0
    '{FN_GET,   PT_SPRITE,  5'd0,  1'b1, 1'b0, 5'd0},
    '{FN_RECL,  PT_SPRITE,  5'd3,  1'b1, 1'b0, 5'd0},
    '{FN_FLUSH, PT_PRIMARY, 5'd0,  1'b1, 1'b0, 5'd0},
    '{FN_QUERY, PT_SPRITE,  5'd0,  1'b1, 1'b0, 5'd0},
    '{FN_PUT,   PT_SPRITE,  5'd31, 1'b1, 1'b1, 5'd0},   // put works without init
    '{FN_PUT,   PT_PRIMARY, 5'd0,  1'b1, 1'b0, 5'd0},
    '{FN_RSVD6, PT_SPRITE,  5'd0,  1'b1, 1'b0, 5'd0},
    '{FN_RSVD7, PT_OVERLAY, 5'd31, 1'b1, 1'b0, 5'd0},
    '{FN_INIT,  PT_PRIMARY, 5'd0,  1'b1, 1'b1, 5'd0},
    '{FN_GET,   PT_SPRITE,  5'd0,  1'b1, 1'b1, 5'd0},
    '{FN_GET,   PT_PRIMARY, 5'd1,  1'b1, 1'b1, 5'd1},
    '{FN_GET,   PT_PRIMARY, 5'd1,  1'b1, 1'b0, 5'd0},   // pipe bit already taken
    '{FN_GET,   PT_OVERLAY, 5'd0,  1'b1, 1'b0, 5'd0},   // no overlay planes
    '{FN_PUT,   PT_SPRITE,  5'd0,  1'b1, 1'b1, 5'd0},
    '{FN_PUT,   PT_SPRITE,  5'd0,  1'b1, 1'b0, 5'd0},   // already free
    '{FN_RECL,  PT_SPRITE,  5'd31, 1'b1, 1'b1, 5'd0},
    '{FN_RECL,  PT_OVERLAY, 5'd5,  1'b1, 1'b1, 5'd0},
    '{FN_RECL,  PT_INVALID, 5'd2,  1'b1, 1'b0, 5'd0},
    '{FN_GET,   PT_INVALID, 5'd0,  1'b1, 1'b0, 5'd0},
    '{FN_QUERY, PT_INVALID, 5'd0,  1'b1, 1'b0, 5'd0},
    '{FN_QUERY, PT_SPRITE,  5'd31, 1'b0, 1'b0, 5'd0},
    '{FN_GET,   PT_SPRITE,  5'd0,  1'b1, 1'b1, 5'd31},  // reclaimed plane goes first
    '{FN_RECL,  PT_PRIMARY, 5'd1,  1'b1, 1'b1, 5'd0},
    '{FN_RECL,  PT_SPRITE,  5'd7,  1'b1, 1'b1, 5'd0},
    '{FN_FLUSH, PT_PRIMARY, 5'd0,  1'b0, 1'b0, 5'd0},   // overlay count 0 stays put
    '{FN_QUERY, PT_PRIMARY, 5'd1,  1'b0, 1'b0, 5'd0},
    '{FN_QUERY, PT_OVERLAY, 5'd5,  1'b0, 1'b0, 5'd0}
  };

  display_plane_bitmap_allocator_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Low count bits of a type, count capped at the map width
  function automatic logic [31:0] present_mask(input logic [5:0] cnt);
    if (cnt >= 6'd32) begin
      return '1;
    end
    return (32'd1 << cnt) - 32'd1;
  endfunction

  // Append one expected result word to the scoreboard
  function automatic void enqueue_result(input res_t r);
    pending_results = {pending_results, r};
  endfunction

  // Expected result of one word; updates the allocator state
  function automatic res_t alloc_outcome(input logic [2:0] fn, input logic [1:0] pt,
                                         input logic [4:0] ix);
    res_t        r;
    logic [31:0] sel;
    logic [31:0] avail;
    logic [31:0] gone [3];
    logic [1:0]  t;
    logic        valid;
    int          low;
    r     = '0;
    valid = (pt != PT_INVALID);
    t     = valid ? pt : PT_PRIMARY;
    sel   = 32'd1 << ix;
    case (fn)
      FN_GET: begin
        if (alloc_ready && valid) begin
          if (t == PT_PRIMARY) begin
            if ((recl_map[t] & sel) != 0) begin
              recl_map[t] &= ~sel;
              r.ok = 1'b1;
            end else if ((free_map[t] & sel) != 0) begin
              free_map[t] &= ~sel;
              r.ok = 1'b1;
            end
            if (r.ok) r.granted_index = ix;
          end else begin
            // lowest reclaimed plane first, then lowest free one
            low = -1;
            for (int i = 31; i >= 0; i--) if (recl_map[t][i]) low = i;
            if (low >= 0) begin
              recl_map[t][low] = 1'b0;
            end else begin
              for (int i = 31; i >= 0; i--) if (free_map[t][i]) low = i;
              if (low >= 0) free_map[t][low] = 1'b0;
            end
            if (low >= 0) begin
              r.ok = 1'b1;
              r.granted_index = 5'(low);
            end
          end
        end
      end
      FN_PUT: begin
        if ((pt == PT_SPRITE || pt == PT_OVERLAY) && free_map[t][ix] == 1'b0) begin
          free_map[t][ix] = 1'b1;
          r.ok = 1'b1;
        end
      end
      FN_RECL: begin
        if (alloc_ready && valid && recl_map[t][ix] == 1'b0) begin
          recl_map[t][ix] = 1'b1;
          r.ok = 1'b1;
        end
      end
      FN_FLUSH: begin
        if (alloc_ready) begin
          for (int i = 0; i < 3; i++) begin
            gone[i] = '0;
            if (plane_cnt[i] != 0 && recl_map[i] != 0) begin
              gone[i] = recl_map[i] & present_mask(plane_cnt[i]);
              free_map[i] |= recl_map[i];
              recl_map[i] = '0;
            end
          end
          r.ok = 1'b1;
          r.primary_disabled_mask = gone[PT_PRIMARY];
          r.sprite_disabled_mask  = gone[PT_SPRITE];
          r.overlay_disabled_mask = gone[PT_OVERLAY];
        end
      end
      FN_INIT: begin
        for (int i = 0; i < 3; i++) begin
          free_map[i] = present_mask(plane_cnt[i]);
          recl_map[i] = '0;
        end
        alloc_ready = 1'b1;
        r.ok = 1'b1;
      end
      FN_QUERY: begin
        if (alloc_ready && valid) begin
          avail = free_map[t] | recl_map[t];
          r.ok = 1'b1;
          r.free_count = 6'($countones(avail));
          r.any_free = (avail != 0);
          r.has_reclaimed = (recl_map[t] != 0);
          r.index_available = avail[ix];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one word, sometimes after a random gap (never while quiet), and wait until it is taken
  task automatic push_word(input logic [2:0] fn, input logic [1:0] pt, input logic [4:0] ix,
                           output res_t pred);
    if (!quiet && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {pt, fn};
    in_tdata  <= {3'b000, ix};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = alloc_outcome(fn, pt, ix);
  endtask

  // Drain every outstanding result before touching the registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_count(input logic [1:0] reg_idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    plane_cnt[reg_idx] = value[5:0];
  endtask

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result side: random stalls except in the quiet stretch
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 30);
  end

  // Result checker
  always @(posedge clk) begin
    res_t got_r;
    res_t want_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_r = res_t'(out_tdata[110:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word 0x%0h", $time, out_tdata);
        mismatches++;
      end else begin
        want_r = pending_results.pop_front();
        cmp_field("ok", 32'(want_r.ok), 32'(got_r.ok));
        cmp_field("granted_index", 32'(want_r.granted_index), 32'(got_r.granted_index));
        cmp_field("free_count", 32'(want_r.free_count), 32'(got_r.free_count));
        cmp_field("any_free", 32'(want_r.any_free), 32'(got_r.any_free));
        cmp_field("has_reclaimed", 32'(want_r.has_reclaimed), 32'(got_r.has_reclaimed));
        cmp_field("index_available", 32'(want_r.index_available),
                  32'(got_r.index_available));
        cmp_field("sprite_disabled_mask", want_r.sprite_disabled_mask,
                  got_r.sprite_disabled_mask);
        cmp_field("primary_disabled_mask", want_r.primary_disabled_mask,
                  got_r.primary_disabled_mask);
        cmp_field("overlay_disabled_mask", want_r.overlay_disabled_mask,
                  got_r.overlay_disabled_mask);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    res_t        pred;
    res_t        typed;
    logic [2:0]  fn;
    logic [1:0]  pt;
    logic [4:0]  ix;
    logic [31:0] cnt_val [3];
    int          pick;
    int          lim;
    for (int i = 0; i < 3; i++) begin
      free_map[i]  = '0;
      recl_map[i]  = '0;
      plane_cnt[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening sequence
    write_count(REG_PRIMARY_COUNT, 32'd2);
    write_count(REG_SPRITE_COUNT, 32'd63);
    write_count(REG_OVERLAY_COUNT, 32'd0);
    for (int r = 0; r < OPENING_ROWS; r++) begin
      push_word(opening[r].fn, opening[r].pt, opening[r].ix, pred);
      if (opening[r].known) begin
        typed = '0;
        typed.ok = opening[r].ok;
        typed.granted_index = opening[r].grant;
        enqueue_result(typed);
      end else begin
        enqueue_result(pred);
      end
    end

    // random phases, each with its own plane counts
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      for (int i = 0; i < 3; i++) begin
        pick = $urandom_range(99);
        case (ph)
          0:       cnt_val[i] = 32;
          1:       cnt_val[i] = 0;
          2:       cnt_val[i] = 1;
          default: begin
            if (pick < 30)      cnt_val[i] = $urandom_range(4);
            else if (pick < 55) cnt_val[i] = $urandom_range(32);
            else if (pick < 65) cnt_val[i] = $urandom_range(63, 33);
            else                cnt_val[i] = $urandom_range(12, 5);
          end
        endcase
      end
      write_count(REG_PRIMARY_COUNT, cnt_val[0]);
      write_count(REG_SPRITE_COUNT, cnt_val[1]);
      write_count(REG_OVERLAY_COUNT, cnt_val[2]);
      quiet = (ph == 4);
      push_word(FN_INIT, 2'($urandom_range(3)), 5'($urandom_range(31)), pred);
      enqueue_result(pred);
      for (int n = 0; n < WORDS_PER_PH; n++) begin
        pick = $urandom_range(99);
        if (pick < 30)      fn = FN_GET;
        else if (pick < 50) fn = FN_PUT;
        else if (pick < 68) fn = FN_RECL;
        else if (pick < 83) fn = FN_QUERY;
        else if (pick < 90) fn = FN_FLUSH;
        else if (pick < 93) fn = FN_INIT;
        else if (pick < 96) fn = FN_RSVD6;
        else                fn = FN_RSVD7;
        pt = ($urandom_range(19) == 0) ? PT_INVALID : 2'($urandom_range(2));
        // indexes mostly around the planes present, so maps fill and drain
        lim = (pt == PT_INVALID) ? 4 : int'(plane_cnt[pt]);
        if (lim == 0) lim = 3;
        if (lim > 31) lim = 31;
        ix = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(lim));
        push_word(fn, pt, ix, pred);
        enqueue_result(pred);
      end
    end

    // drain and let any stray word show up
    quiet = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: display_plane_bitmap_allocator_core.f
rtl/dpba_pkg.sv
rtl/dpba_cfg_regs.sv
rtl/dpba_alloc.sv
rtl/display_plane_bitmap_allocator_core.sv
tb/testbench.sv
